### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behaviour.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/ntsp_pkg.sv
// Shared types, codes and helper functions of the NMEA time sentence parser.
// No dependencies; used by the front, queue, back and top-level files.
package ntsp_pkg;

	localparam int MAX_LEN_DEFAULT     = 128;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef enum logic [2:0] {
		OUT_ZDA      = 3'd0,
		OUT_GGA      = 3'd1,
		OUT_RMC      = 3'd2,
		OUT_BAD_SUM  = 3'd3,
		OUT_OTHER    = 3'd4,
		OUT_TOO_LONG = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		ACT_KEEP  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_CLEAR = 2'd2
	} clock_action_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_ZDA  = 2'd1,
		SRC_GGA  = 2'd2,
		SRC_RMC  = 2'd3
	} fix_mode_t;

	// One received character together with its classification.
	typedef struct packed {
		logic [7:0] data;
		logic       is_dollar;
		logic       is_star;
		logic       is_comma;
		logic       is_lf;
		logic       is_digit;
		logic       hex_ok;
		logic [3:0] hex;
	} word_t;

	// Expected header character at position pos for candidate cand
	// (0 ZDA, 1 GGA, 2 RMC).
	function automatic logic [7:0] hdr_char(input logic [1:0] cand, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (pos)
			3'd0: c = CH_DOLLAR;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = (cand == 2'd0) ? 8'h5A : (cand == 2'd1) ? 8'h47 : 8'h52;
			3'd4: c = (cand == 2'd0) ? 8'h44 : (cand == 2'd1) ? 8'h47 : 8'h4D;
			3'd5: c = (cand == 2'd2) ? 8'h43 : 8'h41;
			3'd6: c = CH_COMMA;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Decimal accumulate of a two-digit group, saturating at 99.
	function automatic logic [6:0] acc99(input logic [6:0] g, input logic [3:0] d);
		logic [10:0] v;
		v = {4'd0, g} * 11'd10 + {7'd0, d};
		return (v > 11'd99) ? 7'd99 : v[6:0];
	endfunction

endpackage

### rtl/core/ntsp_front.sv
// Front end: takes received bytes, drops carriage returns and classifies the rest.
// Depends on ntsp_pkg for the word type and character codes.
module ntsp_front import ntsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       in_valid,
	output logic       in_ready,
	output word_t      word,
	output logic       word_valid,
	input  logic       word_ready
);

	word_t word_c;
	word_t word_s1;
	logic  valid_s1;

	always_comb begin
		word_c.data      = rx_byte;
		word_c.is_dollar = (rx_byte == CH_DOLLAR);
		word_c.is_star   = (rx_byte == CH_STAR);
		word_c.is_comma  = (rx_byte == CH_COMMA);
		word_c.is_lf     = (rx_byte == CH_LF);
		word_c.is_digit  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
		word_c.hex_ok    = 1'b1;
		word_c.hex       = 4'd0;
		priority if (word_c.is_digit) begin
			word_c.hex = rx_byte[3:0];
		end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46)
				|| (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
			word_c.hex = rx_byte[3:0] + 4'd9;
		end else begin
			word_c.hex_ok = 1'b0;
		end
	end

	assign in_ready   = !valid_s1 || word_ready;
	assign word       = word_s1;
	assign word_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			// A carriage return changes nothing downstream, so it never enters the queue.
			valid_s1 <= (rx_byte != CH_CR);
		end else if (word_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word_c;
		end
	end

endmodule

### rtl/core/ntsp_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Depends on ntsp_pkg for the word type.
module ntsp_queue import ntsp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  word_t push_word,
	input  logic  push_valid,
	output logic  push_ready,
	output word_t pop_word,
	output logic  pop_valid,
	input  logic  pop_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	word_t          store_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = store_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_word;
		end
	end

endmodule

### rtl/core/ntsp_back.sv
// Back end: sentence state, field decoding, report generation and output register.
// Depends on ntsp_pkg for the word type, codes and helper functions.
module ntsp_back import ntsp_pkg::*; #(
	parameter int MAX_SENTENCE_LEN = MAX_LEN_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  word_t       word,
	input  logic        word_valid,
	output logic        word_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  outcome,
	output logic [1:0]  clock_action,
	output logic        fix_ok,
	output logic        zda_locked,
	output logic [6:0]  hours,
	output logic [6:0]  minutes,
	output logic [6:0]  seconds,
	output logic        date_present,
	output logic [6:0]  day,
	output logic [6:0]  month,
	output logic [13:0] year
);

	typedef struct packed {
		logic [7:0]  cc;
		logic [7:0]  xsum;
		logic [3:0]  fi;
		logic [2:0]  pos;
		logic [2:0]  hm;
		logic        star;
		logic [7:0]  sent_ck;
		logic [1:0]  hc;
		logic [20:0] tdig;
		logic [27:0] ddig;
		logic [3:0]  qual;
		logic        status;
		logic        ov;
		logic        run;
	} sent_t;

	localparam sent_t SENT_RESET = '{
		cc: 8'd0, xsum: 8'd0, fi: 4'd0, pos: 3'd0, hm: 3'b111, star: 1'b0,
		sent_ck: 8'd0, hc: 2'd0, tdig: 21'd0, ddig: 28'd0, qual: 4'd0,
		status: 1'b0, ov: 1'b0, run: 1'b1
	};

	sent_t       sen_q;
	sent_t       base;
	sent_t       sen_n;
	fix_mode_t   mode_q;
	fix_mode_t   mode_n;
	logic        fixv_q;
	logic        fixv_n;
	logic        out_valid_q;
	logic        report;
	logic        take;
	outcome_t    oc;
	clock_action_t act;
	logic [3:0]  dval;
	logic [17:0] yr_acc;
	logic [7:0]  q_acc;

	logic [2:0]  outcome_q;
	logic [1:0]  action_q;
	logic        fix_ok_q;
	logic        locked_q;
	logic [20:0] tdig_q;
	logic        date_q;
	logic [27:0] ddig_q;

	// A line feed that closes a non-empty sentence needs the output register.
	assign report     = word.is_lf && (sen_q.cc != 8'd0);
	assign word_ready = !report || !out_valid_q || out_ready;
	assign take       = word_valid && word_ready;
	assign dval       = word.data[3:0];

	always_comb begin
		base   = word.is_dollar ? SENT_RESET : sen_q;
		sen_n  = base;
		mode_n = mode_q;
		fixv_n = fixv_q;
		act    = ACT_KEEP;
		oc     = OUT_OTHER;
		yr_acc = {4'd0, base.ddig[13:0]} * 18'd10 + {14'd0, dval};
		q_acc  = {4'd0, base.qual} * 8'd10 + {4'd0, dval};

		if (word.is_lf) begin
			priority if (sen_q.ov) begin
				oc = OUT_TOO_LONG;
			end else if (!(sen_q.star && sen_q.hc == 2'd2 && sen_q.sent_ck == sen_q.xsum)) begin
				oc = OUT_BAD_SUM;
			end else if (sen_q.cc >= 8'd7 && sen_q.hm[0]) begin
				oc = OUT_ZDA;
			end else if (sen_q.cc >= 8'd7 && sen_q.hm[1]) begin
				oc = OUT_GGA;
			end else if (sen_q.cc >= 8'd7 && sen_q.hm[2]) begin
				oc = OUT_RMC;
			end else begin
				oc = OUT_OTHER;
			end

			if (oc == OUT_ZDA) begin
				mode_n = SRC_ZDA;
				act    = ACT_LOAD;
			end else if (oc == OUT_GGA || oc == OUT_RMC) begin
				fixv_n = (oc == OUT_GGA) ? (sen_q.qual != 4'd0) : sen_q.status;
				// Once a ZDA has been taken, GGA and RMC only update the fix flag.
				if (mode_q != SRC_ZDA) begin
					mode_n = (oc == OUT_GGA) ? SRC_GGA : SRC_RMC;
					act    = fixv_n ? ACT_LOAD : ACT_CLEAR;
				end
			end
			sen_n = SENT_RESET;
		end else begin
			if (base.cc >= 8'(MAX_SENTENCE_LEN)) begin
				sen_n.ov = 1'b1;
			end
			if (base.cc < 8'd7) begin
				for (int c = 0; c < 3; c++) begin
					if (hdr_char(2'(c), base.cc[2:0]) != word.data) begin
						sen_n.hm[c] = 1'b0;
					end
				end
			end

			if (base.star) begin
				if (!base.hc[1] && word.hex_ok) begin
					sen_n.sent_ck = {base.sent_ck[3:0], word.hex};
					sen_n.hc      = base.hc + 2'd1;
				end else begin
					sen_n.hc = 2'd3;
				end
			end else if (word.is_star) begin
				sen_n.star = 1'b1;
			end else begin
				if (base.cc != 8'd0) begin
					sen_n.xsum = base.xsum ^ word.data;
				end
				if (word.is_comma) begin
					if (base.fi != 4'd15) begin
						sen_n.fi = base.fi + 4'd1;
					end
					sen_n.pos = 3'd0;
					sen_n.run = 1'b1;
				end else if (base.fi != 4'd0) begin
					if (!word.is_digit) begin
						sen_n.run = 1'b0;
					end
					if (base.fi == 4'd2 && base.pos == 3'd0 && word.data == CH_A) begin
						sen_n.status = 1'b1;
					end
					// Only the leading run of digits of a field is accumulated.
					if (word.is_digit && base.run) begin
						priority if (base.fi == 4'd1) begin
							unique case (base.pos[2:1])
								2'd0: sen_n.tdig[20:14] = acc99(base.tdig[20:14], dval);
								2'd1: sen_n.tdig[13:7]  = acc99(base.tdig[13:7], dval);
								2'd2: sen_n.tdig[6:0]   = acc99(base.tdig[6:0], dval);
								default: sen_n.tdig = base.tdig;
							endcase
						end else if (base.fi == 4'd2) begin
							sen_n.ddig[27:21] = acc99(base.ddig[27:21], dval);
						end else if (base.fi == 4'd3) begin
							sen_n.ddig[20:14] = acc99(base.ddig[20:14], dval);
						end else if (base.fi == 4'd4) begin
							sen_n.ddig[13:0] = (yr_acc > 18'd9999) ? 14'd9999 : yr_acc[13:0];
						end else if (base.fi == 4'd6) begin
							sen_n.qual = (q_acc > 8'd15) ? 4'd15 : q_acc[3:0];
						end else begin
							sen_n.qual = base.qual;
						end
					end
					if (base.pos != 3'd7) begin
						sen_n.pos = base.pos + 3'd1;
					end
				end
			end
			if (base.cc != 8'd255) begin
				sen_n.cc = base.cc + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sen_q       <= SENT_RESET;
			mode_q      <= SRC_NONE;
			fixv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				sen_q  <= sen_n;
				mode_q <= mode_n;
				fixv_q <= fixv_n;
			end
			if (take && report) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && report) begin
			outcome_q <= oc;
			action_q  <= act;
			fix_ok_q  <= fixv_n;
			locked_q  <= (mode_n == SRC_ZDA);
			tdig_q    <= (oc == OUT_ZDA || oc == OUT_GGA || oc == OUT_RMC) ? sen_q.tdig : '0;
			date_q    <= (oc == OUT_ZDA);
			ddig_q    <= (oc == OUT_ZDA) ? sen_q.ddig : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign clock_action = action_q;
	assign fix_ok       = fix_ok_q;
	assign zda_locked   = locked_q;
	assign hours        = tdig_q[20:14];
	assign minutes      = tdig_q[13:7];
	assign seconds      = tdig_q[6:0];
	assign date_present = date_q;
	assign day          = ddig_q[27:21];
	assign month        = ddig_q[20:14];
	assign year         = ddig_q[13:0];

endmodule

### rtl/core/nmea_time_sentence_parser.sv
// NMEA time sentence parser: one received character enters per word, and a report
// leaves for each line feed that closes a non-empty sentence. The block takes one
// word every clock cycle unless a full queue holds it off; an accepted character
// passes the classification register and then the queue before it reaches the
// sentence state, and the report of a closing line feed enters an output register on
// the edge that updates the sentence state. The back end takes one queued word a cycle
// and halts only when a closing line feed finds the previous report still untaken,
// while the queue of QUEUE_DEPTH words lets input continue meanwhile.
`include "assert_macros.svh"

module nmea_time_sentence_parser import ntsp_pkg::*; #(
	parameter int MAX_SENTENCE_LEN = MAX_LEN_DEFAULT,
	parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  outcome,
	output logic [1:0]  clock_action,
	output logic        fix_ok,
	output logic        zda_locked,
	output logic [6:0]  hours,
	output logic [6:0]  minutes,
	output logic [6:0]  seconds,
	output logic        date_present,
	output logic [6:0]  day,
	output logic [6:0]  month,
	output logic [13:0] year
);

	word_t f_word;
	logic  f_valid;
	logic  f_ready;
	word_t q_word;
	logic  q_valid;
	logic  q_ready;

	ntsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.word       (f_word),
		.word_valid (f_valid),
		.word_ready (f_ready)
	);

	ntsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_word  (f_word),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_word   (q_word),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	ntsp_back #(
		.MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word         (q_word),
		.word_valid   (q_valid),
		.word_ready   (q_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.outcome      (outcome),
		.clock_action (clock_action),
		.fix_ok       (fix_ok),
		.zda_locked   (zda_locked),
		.hours        (hours),
		.minutes      (minutes),
		.seconds      (seconds),
		.date_present (date_present),
		.day          (day),
		.month        (month),
		.year         (year)
	);

	// Error and foreign sentences never touch the clock or carry time fields.
	`AST_IMP(a_err_keeps, out_valid && outcome > 3'd2,
		clock_action == ACT_KEEP && hours == 7'd0 && minutes == 7'd0 && seconds == 7'd0)
	// Only a ZDA report carries a date, and it always loads and locks.
	`AST_IMP(a_date_zda, out_valid && date_present,
		outcome == OUT_ZDA && zda_locked && clock_action == ACT_LOAD)
	// Clearing the time follows only from an invalid fix.
	`AST_IMP(a_clear_nofix, out_valid && clock_action == ACT_CLEAR, !fix_ok && !zda_locked)
	// Once locked, a later report stays locked.
	`AST_NEXT(a_lock_holds, out_valid && out_ready && zda_locked, !out_valid || zda_locked)

endmodule
